// ===== rtl/epsm_pkg.sv =====
// package for the encoder period speed meter
// types, widths and register codes shared by every file of the block
// no dependencies
package epsm_pkg;

    // data path widths
    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int CNT_W   = $clog2(DATA_W);

    // configuration port
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD_SHIFT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INSTANT_NUM  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AVERAGE_NUM  = 2'd2;

    // register reset values
    localparam logic [SHIFT_W-1:0] PERIOD_SHIFT_RST = 5'd3;
    localparam logic [DATA_W-1:0]  INSTANT_NUM_RST  = 32'd100000000;
    localparam logic [DATA_W-1:0]  AVERAGE_NUM_RST  = 32'd800000000;

    // configuration seen by the front and back parts
    typedef struct packed {
        logic [SHIFT_W-1:0] period_shift;
        logic [DATA_W-1:0]  instant_numerator;
        logic [DATA_W-1:0]  average_numerator;
    } cfg_t;

endpackage

// ===== rtl/epsm_if.sv =====
// valid/ready channel interfaces for the encoder period speed meter
// one for timer readings in, one for rate results out; depends on epsm_pkg
interface epsm_in_if;
    import epsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] timer_value;

    modport source (output valid, output timer_value, input ready);
    modport sink   (input valid, input timer_value, output ready);
endinterface

interface epsm_out_if;
    import epsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] instant_rate;
    logic [DATA_W-1:0] average_rate;

    modport source (output valid, output instant_rate, output average_rate, input ready);
    modport sink   (input valid, input instant_rate, input average_rate, output ready);
endinterface

// ===== rtl/encoder_period_speed_meter.sv =====
// Encoder period speed meter, top level.
// Timer readings come in on sample_in (valid/ready, timer_value); each one
// gives one request on rate_out with instant_rate and average_rate.
// The period is ~timer_value shifted right by period_shift; a ring of the
// last WINDOW_DEPTH periods and their running sum give the window average.
// Each rate is numerator / divisor, all ones when the divisor is zero.
// Registers on the APB port: 0x0 period_shift, 0x4 instant_numerator,
// 0x8 average_numerator; write only while the block is idle.
// Each item goes through the two 32-step restoring dividers in the back
// part, which take no new item until both are done and the result is
// loaded; the front part takes no new reading until its update is pushed.
// A two-entry queue sits between the ring update and the dividers, and the
// result sits in an output register, so the front keeps taking readings
// while the receiver stalls until queue and output register are full.
// Reset clears the ring (through per-entry valid bits), the sum, the ring
// position and all handshakes, and loads the register defaults; no
// clearing pass is needed.
// depends on epsm_pkg, epsm_if, epsm_front, epsm_fifo, epsm_back
module encoder_period_speed_meter #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    epsm_in_if.sink                     sample_in,
    epsm_out_if.source                  rate_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epsm_pkg::ADDR_W-1:0] paddr,
    input  logic [epsm_pkg::DATA_W-1:0] pwdata,
    output logic [epsm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import epsm_pkg::*;

    localparam int SUM_W   = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int ENTRY_W = DATA_W + SUM_W;

    logic [SHIFT_W-1:0]   period_shift_reg;
    logic [DATA_W-1:0]    instant_num_reg;
    logic [DATA_W-1:0]    average_num_reg;
    cfg_t                 cfg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 push_valid;
    logic                 push_ready;
    logic [DATA_W-1:0]    push_period;
    logic [SUM_W-1:0]     push_sum;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [ENTRY_W-1:0]   pop_data;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_shift_reg <= PERIOD_SHIFT_RST;
            instant_num_reg  <= INSTANT_NUM_RST;
            average_num_reg  <= AVERAGE_NUM_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PERIOD_SHIFT: period_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_INSTANT_NUM:  instant_num_reg  <= pwdata;
                REG_AVERAGE_NUM:  average_num_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_PERIOD_SHIFT: prdata = DATA_W'(period_shift_reg);
            REG_INSTANT_NUM:  prdata = instant_num_reg;
            REG_AVERAGE_NUM:  prdata = average_num_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.period_shift      = period_shift_reg;
    assign cfg.instant_numerator = instant_num_reg;
    assign cfg.average_numerator = average_num_reg;

    // period forming and ring update
    epsm_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .sample_in   (sample_in),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_period (push_period),
        .push_sum    (push_sum)
    );

    // queue of period and sum pairs
    epsm_fifo #(
        .ENTRY_W (ENTRY_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_period, push_sum}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // rate division and result register
    epsm_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_period (pop_data[ENTRY_W-1:SUM_W]),
        .pop_sum    (pop_data[SUM_W-1:0]),
        .rate_out   (rate_out)
    );

endmodule

// ===== rtl/epsm_div.sv =====
// radix-2 restoring divider, 32-bit dividend over a DEN_W-bit divisor
// one quotient bit per cycle; depends on epsm_pkg
module epsm_div #(
    parameter int DEN_W = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [epsm_pkg::DATA_W-1:0] num,
    input  logic [DEN_W-1:0]           den,
    output logic                       busy,
    output logic [epsm_pkg::DATA_W-1:0] quotient
);
    import epsm_pkg::*;

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;
    logic              take;

    // one trial subtraction; a zero divisor always subtracts, giving all ones
    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, den_reg};
    assign take     = !diff[DEN_W+1];
    assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient; dividend bits shift out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/epsm_fifo.sv =====
// two-entry queue between the front and back parts
// registered entries with read and write pointers; depends on epsm_pkg
module epsm_fifo #(
    parameter int ENTRY_W = 67
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  logic [ENTRY_W-1:0] push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output logic [ENTRY_W-1:0] pop_data
);
    import epsm_pkg::*;

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               push;
    logic               pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/epsm_front.sv =====
// front part: takes a timer reading, forms the shifted period and keeps
// the ring of recent periods and their running sum; depends on epsm_pkg, epsm_if
module epsm_front #(
    parameter int WINDOW_DEPTH = 8,
    parameter int SUM_W        = 35
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  epsm_pkg::cfg_t              cfg,
    epsm_in_if.sink                     sample_in,
    output logic                        push_valid,
    input  logic                        push_ready,
    output logic [epsm_pkg::DATA_W-1:0] push_period,
    output logic [SUM_W-1:0]            push_sum
);
    import epsm_pkg::*;

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                    state_reg;
    logic [PTR_W-1:0]        pos_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic                    old_valid_reg;
    logic [DATA_W-1:0]       old_raw_reg;
    logic [DATA_W-1:0]       old_period;
    logic [DATA_W-1:0]       period_reg;
    logic [DATA_W-1:0]       ring_mem [WINDOW_DEPTH];
    logic                    accept;
    logic                    push;

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign accept          = sample_in.valid && sample_in.ready;
    assign push_valid      = (state_reg == ST_UPDATE);
    assign push            = push_valid && push_ready;

    // an entry never written since reset reads as zero
    assign old_period = old_valid_reg ? old_raw_reg : '0;
    assign sum_next   = sum_reg - SUM_W'(old_period) + SUM_W'(period_reg);

    assign push_period = period_reg;
    assign push_sum    = sum_next;

    // control, entry valid bits, ring position and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        old_valid_reg <= valid_reg[pos_reg];
                        state_reg     <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (push)
                    begin
                        sum_reg            <= sum_next;
                        valid_reg[pos_reg] <= 1'b1;
                        pos_reg            <= (pos_reg == PTR_W'(WINDOW_DEPTH - 1)) ?
                                              '0 : pos_reg + 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // period capture and ring memory, read on accept and written on push
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            period_reg  <= (~sample_in.timer_value) >> cfg.period_shift;
            old_raw_reg <= ring_mem[pos_reg];
        end
        if (push)
        begin
            ring_mem[pos_reg] <= period_reg;
        end
    end

endmodule

// ===== rtl/epsm_back.sv =====
// back part: two iterative dividers for the instant and averaged rates
// and the output register; depends on epsm_pkg, epsm_if, epsm_div
module epsm_back #(
    parameter int SUM_W = 35
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  epsm_pkg::cfg_t              cfg,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [epsm_pkg::DATA_W-1:0] pop_period,
    input  logic [SUM_W-1:0]            pop_sum,
    epsm_out_if.source                  rate_out
);
    import epsm_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DIVIDE = 1'b1;

    logic              state_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] instant_reg;
    logic [DATA_W-1:0] average_reg;
    logic              start;
    logic              inst_busy;
    logic              avg_busy;
    logic [DATA_W-1:0] inst_quo;
    logic [DATA_W-1:0] avg_quo;
    logic              slot_free;
    logic              load;

    assign pop_ready = (state_reg == ST_IDLE);
    assign start     = pop_valid && pop_ready;
    assign slot_free = !out_valid_reg || rate_out.ready;
    assign load      = (state_reg == ST_DIVIDE) && !inst_busy && !avg_busy && slot_free;

    // instant rate: numerator over the latest period
    epsm_div #(
        .DEN_W (DATA_W)
    ) u_inst_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .num      (cfg.instant_numerator),
        .den      (pop_period),
        .busy     (inst_busy),
        .quotient (inst_quo)
    );

    // averaged rate: numerator over the window sum
    epsm_div #(
        .DEN_W (SUM_W)
    ) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .num      (cfg.average_numerator),
        .den      (pop_sum),
        .busy     (avg_busy),
        .quotient (avg_quo)
    );

    // sequencing and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rate_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            instant_reg <= inst_quo;
            average_reg <= avg_quo;
        end
    end

    assign rate_out.valid        = out_valid_reg;
    assign rate_out.instant_rate = instant_reg;
    assign rate_out.average_rate = average_reg;

endmodule

// ===== rtl/epsm_checker.sv =====
// port-level checker for the encoder period speed meter, with its bind
// depends on epsm_pkg and the top level encoder_period_speed_meter
module epsm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [epsm_pkg::DATA_W-1:0] instant_rate,
    input  logic [epsm_pkg::DATA_W-1:0] average_rate
);
    import epsm_pkg::*;

    // front, two queue entries, dividers and output register
    localparam int          MAX_INFLIGHT = 5;
    localparam int          OUTST_W      = 4;

    logic [OUTST_W-1:0] outstanding_reg;
    logic               in_fire;
    logic               out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_fire && !out_fire)
        begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // a result is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(instant_rate) && $stable(average_rate))
    else $error("result changed while stalled");

    // no result without a reading behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != '0)
    else $error("result with no pending reading");

    // pipeline never holds more than its storage allows
    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUTST_W'(MAX_INFLIGHT))
    else $error("too many readings in flight");

endmodule

bind encoder_period_speed_meter epsm_checker u_epsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_in.valid),
    .in_ready     (sample_in.ready),
    .out_valid    (rate_out.valid),
    .out_ready    (rate_out.ready),
    .instant_rate (rate_out.instant_rate),
    .average_rate (rate_out.average_rate)
);

// ===== dv/encoder_period_speed_meter_tb.sv =====
`timescale 1ns / 1ps
// testbench for encoder_period_speed_meter: a directed table of timer readings,
// then random readings under several register settings, all rates checked
// depends on epsm_pkg, epsm_if and the rtl of the block
module encoder_period_speed_meter_tb;
    import epsm_pkg::*;

    localparam int WINDOW          = 8;
    localparam int SUM_W           = DATA_W + $clog2(WINDOW);
    localparam int NUM_REGS        = 3;
    localparam int PHASES          = 6;
    localparam int PHASE_READINGS  = 180;
    localparam int PRESSURE_AT     = 600;
    localparam int PRESSURE_CYCLES = 400;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 64;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0]    ALL_ONES   = '1;

    typedef struct packed {
        logic [DATA_W-1:0] instant_rate;
        logic [DATA_W-1:0] average_rate;
    } rates_t;

    typedef struct packed {
        logic [DATA_W-1:0] reading;
        logic              known;
        rates_t            rates;
    } reading_row_t;

    // directed readings, run with the reset register values
    localparam int DIRECTED_COUNT = 21;
    localparam reading_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty ring and zero period: both rates saturate
        '{32'hFFFF_FFFF, 1'b1, '{ALL_ONES, ALL_ONES}},
        // longest period
        '{32'h0000_0000, 1'b1, '{32'd0, 32'd1}},
        // period shifted down to zero
        '{32'hFFFF_FFFE, 1'b1, '{ALL_ONES, 32'd1}},
        '{32'hFFFF_FFF7, 1'b1, '{32'd100000000, 32'd1}},
        // mixed patterns, the ring wraps on the ninth reading
        '{32'hFFFF_F7FF, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h1234_5678, 1'b0, '0},
        '{32'hFFFF_FF00, 1'b0, '0},
        // flush the whole window with zero periods
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        // sum back to zero after a full window of zeros
        '{32'hFFFF_FFFF, 1'b1, '{ALL_ONES, ALL_ONES}},
        '{32'hFFFF_FFF7, 1'b1, '{32'd100000000, 32'd800000000}},
        '{32'hFFFF_FFEF, 1'b1, '{32'd50000000, 32'd266666666}}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    epsm_in_if  sample_in ();
    epsm_out_if rate_out ();

    // predictor state: register copy, period window and its running sum
    cfg_t              meter_cfg;
    logic [DATA_W-1:0] period_hist [WINDOW];
    int unsigned       hist_slot;
    logic [SUM_W-1:0]  hist_sum;

    rates_t      pending_rates [$];
    int unsigned failures       = 0;
    int unsigned readings_taken = 0;
    int unsigned quiet_cycles   = 0;
    bit          steady         = 1'b0;
    bit          pressure_done  = 1'b0;

    encoder_period_speed_meter #(
        .WINDOW_DEPTH (WINDOW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .rate_out  (rate_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // rates for one reading, advances the period window
    function automatic rates_t predict_rates(input logic [DATA_W-1:0] reading);
        logic [DATA_W-1:0] period;
        logic [63:0]       avg;
        rates_t            r;
        period = (ALL_ONES - reading) >> meter_cfg.period_shift;
        hist_sum = hist_sum - SUM_W'(period_hist[hist_slot]) + SUM_W'(period);
        period_hist[hist_slot] = period;
        hist_slot = (hist_slot + 1) % WINDOW;
        if (period == '0)
            r.instant_rate = ALL_ONES;
        else
            r.instant_rate = meter_cfg.instant_numerator / period;
        if (hist_sum == '0)
            r.average_rate = ALL_ONES;
        else
        begin
            avg = 64'(meter_cfg.average_numerator) / 64'(hist_sum);
            r.average_rate = avg[DATA_W-1:0];
        end
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            failures++;
        end
    endtask

    // one timer reading request after a random gap, expectation queued on accept
    task automatic offer_reading(input logic [DATA_W-1:0] reading, input logic known,
                                 input rates_t known_rates);
        int unsigned gap;
        rates_t      predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            sample_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in.valid       <= 1'b1;
        sample_in.timer_value <= reading;
        do @(posedge clk); while (!sample_in.ready);
        predicted = predict_rates(reading);
        pending_rates.push_back(known ? known_rates : predicted);
        readings_taken++;
    endtask

    // apb write, mirrored into the predictor's register copy
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PERIOD_SHIFT: meter_cfg.period_shift = value[SHIFT_W-1:0];
            REG_INSTANT_NUM:  meter_cfg.instant_numerator = value;
            REG_AVERAGE_NUM:  meter_cfg.average_numerator = value;
            default: ;
        endcase
    endtask

    // read back every register over apb
    task automatic check_regs();
        logic [REG_IDX_W-1:0] idx;
        for (int n = 0; n < NUM_REGS; n++)
        begin
            idx = REG_IDX_W'(n);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            case (idx)
                REG_PERIOD_SHIFT:
                    check_field("period_shift", DATA_W'(meter_cfg.period_shift), prdata);
                REG_INSTANT_NUM:
                    check_field("instant_numerator", meter_cfg.instant_numerator, prdata);
                default:
                    check_field("average_numerator", meter_cfg.average_numerator, prdata);
            endcase
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : rate_check
        rates_t want;
        if (rst_n === 1'b1 && rate_out.valid && rate_out.ready)
        begin
            if (pending_rates.size() == 0)
            begin
                $error("rate request with no reading pending: instant %h, average %h",
                       rate_out.instant_rate, rate_out.average_rate);
                failures++;
            end
            else
            begin
                want = pending_rates.pop_front();
                check_field("instant_rate", want.instant_rate, rate_out.instant_rate);
                check_field("average_rate", want.average_rate, rate_out.average_rate);
            end
        end
    end

    // watchdog on cycles with no accepted request anywhere
    always @(posedge clk)
    begin : watchdog
        if ((sample_in.valid && sample_in.ready) || (rate_out.valid && rate_out.ready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL encoder_period_speed_meter");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back up the block
    initial
    begin : receiver
        int unsigned stall;
        rate_out.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (!pressure_done && readings_taken >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                stall = PRESSURE_CYCLES;
            end
            else
                stall = pick_gap();
            if (stall != 0)
            begin
                rate_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rate_out.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [DATA_W-1:0] reading;
        logic [DATA_W-1:0] span;
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        sample_in.valid       <= 1'b0;
        sample_in.timer_value <= '0;
        meter_cfg = '{PERIOD_SHIFT_RST, INSTANT_NUM_RST, AVERAGE_NUM_RST};
        for (int i = 0; i < WINDOW; i++)
            period_hist[i] = '0;
        hist_slot = 0;
        hist_sum  = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_reading(DIRECTED_ROWS[i].reading, DIRECTED_ROWS[i].known,
                          DIRECTED_ROWS[i].rates);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // registers change only once the block has drained
            sample_in.valid <= 1'b0;
            while (pending_rates.size() != 0) @(posedge clk);
            case (ph)
                0:
                begin
                    // upper bits of the shift value are dropped
                    set_reg(REG_PERIOD_SHIFT, 32'hFFFF_FFE0);
                    set_reg(REG_INSTANT_NUM, ALL_ONES);
                    set_reg(REG_AVERAGE_NUM, ALL_ONES);
                    // write past the last register has no effect
                    set_reg(REG_UNUSED, $urandom);
                end
                1:
                begin
                    set_reg(REG_PERIOD_SHIFT, 32'd31);
                    set_reg(REG_INSTANT_NUM, '0);
                    set_reg(REG_AVERAGE_NUM, '0);
                end
                2:
                begin
                    set_reg(REG_PERIOD_SHIFT, 32'd1);
                    set_reg(REG_INSTANT_NUM, INSTANT_NUM_RST);
                    set_reg(REG_AVERAGE_NUM, AVERAGE_NUM_RST);
                end
                default:
                begin
                    set_reg(REG_PERIOD_SHIFT, $urandom);
                    set_reg(REG_INSTANT_NUM, $urandom);
                    set_reg(REG_AVERAGE_NUM, $urandom);
                end
            endcase
            check_regs();
            steady = (ph == 1);

            for (int n = 0; n < PHASE_READINGS; n++)
            begin
                case ($urandom_range(0, 9))
                    0: reading = ALL_ONES;
                    1: reading = '0;
                    2, 3: reading = $urandom;
                    default:
                    begin
                        // periods of every magnitude, short ones most often
                        span = ALL_ONES >> $urandom_range(0, 31);
                        reading = ~(span & $urandom);
                    end
                endcase
                offer_reading(reading, 1'b0, '0);
            end
        end

        sample_in.valid <= 1'b0;
        steady = 1'b0;
        while (pending_rates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS encoder_period_speed_meter");
        else
            $display("FAIL encoder_period_speed_meter");
        $finish;
    end

endmodule
